// ----- rtl/core/vfr_pkg.sv -----
// Package for the vertex first-use remap block.
// Field widths, opcodes, queue item and table entry types. No dependencies.
`timescale 1ns / 1ps

package vfr_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int VCOUNT_W = 13;
  localparam int IDX_W = 12;
  localparam int POS_W = 12;
  localparam int OP_W = 2;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;
  localparam int M_USER_W = 3;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 13'd4096;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_FEED   = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             err;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } entry_t;

endpackage

// ----- rtl/core/vfr_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module vfr_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/vfr_front.sv -----
// Front end: accepts requests and classifies them (opcode, range error).
// Depends on vfr_pkg.
`timescale 1ns / 1ps

module vfr_front import vfr_pkg::*; #(
  parameter int CW = 13
) (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]     s_tuser,
  input  logic [CW-1:0]       eff_count,
  input  logic                init_busy,
  input  logic                q_full,
  output logic                push,
  output item_t               item
);

  op_t              op;
  logic [IDX_W-1:0] idx;
  logic             out_of_range;

  assign op  = op_t'(s_tuser);
  assign idx = s_tdata[IDX_W-1:0];
  assign out_of_range = 32'(idx) >= 32'(eff_count);

  assign s_tready = !q_full && !init_busy;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    item.op  = op;
    item.idx = idx;
    item.err = (op == OP_FEED || op == OP_READ) && out_of_range;
  end

endmodule

// ----- rtl/core/vfr_queue.sv -----
// Short request queue between front and back end.
// Depends on vfr_pkg.
`timescale 1ns / 1ps

module vfr_queue import vfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  valid,
  output item_t head,
  input  logic  pop
);

  item_t           slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full  = count == (Q_AW + 1)'(Q_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_AW + 1)'(1);
      end else if (!push && pop) begin
        count <= count - (Q_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/core/vfr_back.sv -----
// Back end: remap table sequencer (lookup, clear and finish sweeps) and
// output register. Depends on vfr_pkg and vfr_ram.
`timescale 1ns / 1ps

module vfr_back import vfr_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CW-1:0]       eff_count,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                init_busy,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser
);

  localparam int AW = $clog2(MAX_VERTICES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_CLEAR = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic          report, report_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] next_pos, next_pos_next;
  logic          rd_pend, rd_pend_next;
  logic [AW-1:0] rd_addr, rd_addr_next;
  op_t           cur_op, cur_op_next;
  logic [AW-1:0] cur_addr, cur_addr_next;
  logic          out_valid, out_valid_next;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [POS_W:0]      ram_rdata;
  entry_t              rd_entry;

  logic                load;
  logic [POS_W-1:0]    res_pos;
  logic                res_fresh;
  logic                res_has;
  logic                res_err;
  logic [VCOUNT_W-1:0] res_count;

  logic [POS_W-1:0]    o_pos;
  logic                o_fresh;
  logic                o_has;
  logic                o_err;
  logic [VCOUNT_W-1:0] o_count;

  logic                sweep_more;
  logic                start;

  vfr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry   = entry_t'(ram_rdata);
  assign start      = (state == ST_IDLE) && q_valid && !out_valid;
  assign q_pop      = start;
  assign init_busy  = (state == ST_CLEAR) && !report;
  assign sweep_more = ptr < eff_count;

  always_comb begin
    state_next    = state;
    report_next   = report;
    ptr_next      = ptr;
    next_pos_next = next_pos;
    rd_pend_next  = 1'b0;
    rd_addr_next  = rd_addr;
    cur_op_next   = cur_op;
    cur_addr_next = cur_addr;
    ram_we        = 1'b0;
    ram_waddr     = ptr[AW-1:0];
    ram_wdata     = '0;
    ram_raddr     = ptr[AW-1:0];
    load          = 1'b0;
    res_pos       = '0;
    res_fresh     = 1'b0;
    res_has       = 1'b0;
    res_err       = 1'b0;
    res_count     = VCOUNT_W'(next_pos);

    unique case (state)
      ST_IDLE: begin
        ram_raddr = AW'(q_item.idx);
        if (start) begin
          unique case (q_item.op)
            OP_CLEAR: begin
              state_next    = ST_CLEAR;
              report_next   = 1'b1;
              ptr_next      = '0;
              next_pos_next = '0;
            end
            OP_FINISH: begin
              state_next = ST_FIN;
              ptr_next   = '0;
            end
            OP_FEED, OP_READ: begin
              if (q_item.err) begin
                load    = 1'b1;
                res_err = 1'b1;
              end else begin
                state_next    = ST_LOOK;
                cur_op_next   = q_item.op;
                cur_addr_next = AW'(q_item.idx);
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        load       = 1'b1;
        state_next = ST_IDLE;
        if (cur_op == OP_FEED) begin
          res_has = 1'b1;
          if (!rd_entry.valid) begin
            ram_we          = 1'b1;
            ram_waddr       = cur_addr;
            ram_wdata.valid = 1'b1;
            ram_wdata.pos   = POS_W'(next_pos);
            next_pos_next   = next_pos + CW'(1);
            res_pos         = POS_W'(next_pos);
            res_fresh       = 1'b1;
          end else begin
            res_pos = rd_entry.pos;
          end
        end else begin
          res_has = rd_entry.valid;
          res_pos = rd_entry.valid ? rd_entry.pos : '0;
        end
        res_count = VCOUNT_W'(next_pos_next);
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (ptr == CW'(MAX_VERTICES - 1)) begin
          state_next = ST_IDLE;
          load       = report;
        end else begin
          ptr_next = ptr + CW'(1);
        end
      end
      ST_FIN: begin
        // read runs one entry ahead of the write-back
        rd_pend_next = sweep_more;
        if (sweep_more) begin
          ptr_next     = ptr + CW'(1);
          rd_addr_next = ptr[AW-1:0];
        end
        if (rd_pend && !rd_entry.valid) begin
          ram_we          = 1'b1;
          ram_waddr       = rd_addr;
          ram_wdata.valid = 1'b1;
          ram_wdata.pos   = POS_W'(next_pos);
          next_pos_next   = next_pos + CW'(1);
        end
        if (!sweep_more && !rd_pend) begin
          state_next = ST_IDLE;
          load       = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    out_valid_next = load ? 1'b1 : (out_valid && !m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      report    <= 1'b0;
      ptr       <= '0;
      next_pos  <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      report    <= report_next;
      ptr       <= ptr_next;
      next_pos  <= next_pos_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr  <= rd_addr_next;
    cur_op   <= cur_op_next;
    cur_addr <= cur_addr_next;
    if (load) begin
      o_pos   <= res_pos;
      o_fresh <= res_fresh;
      o_has   <= res_has;
      o_err   <= res_err;
      o_count <= res_count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_DATA_W - VCOUNT_W - POS_W)'(0), o_count, o_pos};
  assign m_tuser  = {o_err, o_has, o_fresh};

endmodule

// ----- rtl/core/vertex_first_use_remap.sv -----
// Top level of the vertex first-use remap block: config register, front end,
// request queue and back end. Depends on vfr_pkg, vfr_front, vfr_queue, vfr_back.
`timescale 1ns / 1ps
//
//  channel   dir  signals                          contents
//  config    in   cfg_we, cfg_wdata[12:0]          vertex_count
//  requests  in   s_tvalid/s_tready/s_tdata/s_tuser  index, opcode
//  results   out  m_tvalid/m_tready/m_tdata/m_tuser  position/count, flags
//
//  Feed and read: table read in the back end, then update; an out-of-range
//  index is answered directly from idle. The next request starts the cycle
//  after the result register is taken.
//  Clear: one table entry per cycle over all MAX_VERTICES entries. Finish: one
//  entry per cycle through the table port, up to the effective vertex count.
//  After reset a clearing pass over all MAX_VERTICES entries runs with s_tready low.
//  A two-entry queue lets requests come in while the back end or output stalls.

module vertex_first_use_remap import vfr_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [VCOUNT_W-1:0] cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [11:0] vertex_index
  input  logic [OP_W-1:0]     s_tuser,   // [1:0] opcode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [11:0] new_position, [24:12] assigned_count
  output logic [M_USER_W-1:0] m_tuser    // [0] first_use, [1] assigned, [2] index_error
);

  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [VCOUNT_W-1:0] vertex_count;
  logic [CW-1:0]       eff_count;
  logic                init_busy;
  logic                q_full;
  logic                q_push;
  item_t               q_in;
  logic                q_valid;
  item_t               q_head;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  assign eff_count = (32'(vertex_count) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                              : CW'(vertex_count);

  vfr_front #(
    .CW (CW)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .eff_count (eff_count),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (q_push),
    .item      (q_in)
  );

  vfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  vfr_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .CW           (CW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_count (eff_count),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- sim/vfr_remap_checker.sv -----
// Checker for the vertex first-use remap block: predicts each result from the
// accepted requests and compares the result stream. Depends on vfr_pkg.
`timescale 1ns / 1ps

module vfr_remap_checker import vfr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [VCOUNT_W-1:0] cfg_wdata,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]     s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,
  input  logic [M_USER_W-1:0] m_tuser,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic                fresh;
    logic                has;
    logic                err;
    logic [VCOUNT_W-1:0] total;
  } remap_result_t;

  bit                  slot_set [MAX_VERTICES_DEF];
  logic [POS_W-1:0]    slot_pos [MAX_VERTICES_DEF];
  logic [VCOUNT_W-1:0] next_pos;
  logic [VCOUNT_W-1:0] mesh_vcount;

  remap_result_t remap_results_due[$];
  remap_result_t want_r;
  remap_result_t got_r;
  int            mismatches = 0;

  function automatic void wipe_table();
    for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
      slot_set[i] = 1'b0;
      slot_pos[i] = '0;
    end
    next_pos = '0;
  endfunction

  function automatic remap_result_t predict_remap(op_t op, logic [IDX_W-1:0] idx);
    remap_result_t r;
    int            lim;
    r   = '0;
    lim = (mesh_vcount > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(mesh_vcount);
    case (op)
      OP_CLEAR: begin
        wipe_table();
      end
      OP_FINISH: begin
        for (int i = 0; i < lim; i++) begin
          if (!slot_set[i]) begin
            slot_set[i] = 1'b1;
            slot_pos[i] = next_pos[POS_W-1:0];
            next_pos    = next_pos + 1'b1;
          end
        end
      end
      default: begin
        if (int'(idx) >= lim) begin
          r.err = 1'b1;
        end else if (op == OP_FEED) begin
          if (!slot_set[idx]) begin
            slot_set[idx] = 1'b1;
            slot_pos[idx] = next_pos[POS_W-1:0];
            next_pos      = next_pos + 1'b1;
            r.fresh       = 1'b1;
          end
          r.pos = slot_pos[idx];
          r.has = 1'b1;
        end else if (slot_set[idx]) begin
          r.pos = slot_pos[idx];
          r.has = 1'b1;
        end
      end
    endcase
    r.total = next_pos;
    return r;
  endfunction

  task automatic compare_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mesh_vcount = VCOUNT_RESET;
      wipe_table();
      remap_results_due.delete();
    end else begin
      if (cfg_we)
        mesh_vcount = cfg_wdata;
      if (s_tvalid && s_tready)
        remap_results_due.insert(remap_results_due.size(),
                                 predict_remap(op_t'(s_tuser), s_tdata[IDX_W-1:0]));
      if (m_tvalid && m_tready) begin
        got_r.pos   = m_tdata[POS_W-1:0];
        got_r.total = m_tdata[POS_W +: VCOUNT_W];
        got_r.fresh = m_tuser[0];
        got_r.has   = m_tuser[1];
        got_r.err   = m_tuser[2];
        if (remap_results_due.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %h/%h",
                   $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          want_r = remap_results_due[0];
          remap_results_due.delete(0);
          compare_field("new_position", want_r.pos, got_r.pos);
          compare_field("first_use", want_r.fresh, got_r.fresh);
          compare_field("assigned", want_r.has, got_r.has);
          compare_field("index_error", want_r.err, got_r.err);
          compare_field("assigned_count", want_r.total, got_r.total);
        end
      end
    end
    pending    <= remap_results_due.size();
    fail_count <= mismatches;
  end

endmodule

// ----- sim/tb_vertex_first_use_remap.sv -----
// Testbench top for the vertex first-use remap block: drives requests, config
// writes and result backpressure. Depends on vfr_pkg, vfr_remap_checker and the RTL.
`timescale 1ns / 1ps

module tb_vertex_first_use_remap;
  import vfr_pkg::*;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [VCOUNT_W-1:0] cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic [OP_W-1:0]     s_tuser   = '0;
  logic                m_tready  = 1'b0;
  wire                 s_tready;
  wire                 m_tvalid;
  wire [M_DATA_W-1:0]  m_tdata;
  wire [M_USER_W-1:0]  m_tuser;

  int fail_count;
  int pending;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int request_total = 0;
  logic [VCOUNT_W-1:0] mesh_count = VCOUNT_RESET;

  always #5 clk = ~clk;

  vertex_first_use_remap i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  vfr_remap_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result backpressure; a long hold-off starts when hold_req moves
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(op_t op, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= S_DATA_W'(idx);
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    request_total++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  task automatic write_count(logic [VCOUNT_W-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    mesh_count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly in range for the current mesh, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_index();
    int eff;
    eff = (mesh_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(mesh_count);
    if (eff == 0 || $urandom_range(99) < 8)
      return IDX_W'($urandom_range(4095));
    return IDX_W'($urandom_range(eff - 1));
  endfunction

  initial begin
    int mesh;
    int r;
    int nreq;
    logic [VCOUNT_W-1:0] cnt;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_READ, 12'd0);
    send_request(OP_FEED, 12'd4095);
    send_request(OP_FEED, 12'd0);
    send_request(OP_FEED, 12'd4095);
    send_request(OP_FEED, 12'h555);
    send_request(OP_FEED, 12'hAAA);
    send_request(OP_READ, 12'd4095);
    send_request(OP_READ, 12'd1);
    send_request(OP_FINISH, 12'd0);
    send_request(OP_READ, 12'd4094);
    send_request(OP_FEED, 12'd7);
    send_request(OP_CLEAR, 12'd0);
    write_count(13'd8191);
    send_request(OP_FEED, 12'd4095);
    send_request(OP_READ, 12'd4095);
    send_request(OP_FINISH, 12'd0);
    write_count(13'd0);
    send_request(OP_FEED, 12'd0);
    send_request(OP_READ, 12'd0);
    send_request(OP_FINISH, 12'd0);
    send_request(OP_CLEAR, 12'd0);
    write_count(13'd5);
    send_request(OP_FEED, 12'd5);
    send_request(OP_FEED, 12'd4);
    send_request(OP_READ, 12'd4);
    // shrink the count with vertex 4 already set
    write_count(13'd2);
    send_request(OP_READ, 12'd4);
    send_request(OP_FINISH, 12'd0);
    send_request(OP_READ, 12'd1);

    for (mesh = 0; request_total < 1350; mesh++) begin
      case (mesh % 4)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 71; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 71; end
        default: begin idle_pct <= 19; stall_pct <= 19; end
      endcase
      r = $urandom_range(15);
      case (r)
        0: cnt = 13'd0;
        1: cnt = 13'd8191;
        2: cnt = 13'd4096;
        3: cnt = VCOUNT_W'($urandom_range(8190, 4097));
        4: cnt = VCOUNT_W'($urandom_range(4096, 65));
        5: cnt = 13'd1;
        default: cnt = VCOUNT_W'($urandom_range(64, 2));
      endcase
      write_count(cnt);
      if ($urandom_range(7) != 0)
        send_request(OP_CLEAR, IDX_W'($urandom));
      if (mesh == 2) begin
        // results held back while requests keep coming
        hold_req <= hold_req + 1;
        repeat (24) send_request(OP_FEED, pick_index());
      end
      nreq = $urandom_range(50, 10);
      repeat (nreq) begin
        r = $urandom_range(99);
        if (r < 20)
          send_request(OP_READ, pick_index());
        else if (r < 23)
          send_request(OP_FINISH, IDX_W'($urandom));
        else if (r < 24)
          send_request(OP_CLEAR, IDX_W'($urandom));
        else
          send_request(OP_FEED, pick_index());
      end
      if ($urandom_range(3) == 0) begin
        write_count(VCOUNT_W'($urandom_range(80)));
        repeat (10) send_request(OP_FEED, pick_index());
      end
      if ($urandom_range(3) != 0)
        send_request(OP_FINISH, IDX_W'($urandom));
      repeat ($urandom_range(6, 2)) send_request(OP_READ, pick_index());
      if (mesh % 5 == 4)
        wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
